// ===== rtl/core/clpm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the chained pipeline latency monitor.
package clpm_pkg;

    localparam int STAGES      = 4;
    localparam int STAGE_W     = 2;
    localparam int OP_W        = 3;
    localparam int TIME_W      = 62;
    localparam int LAT_W       = 24;
    localparam int NS_PER_US   = 1000;
    localparam int PROD_W      = 34;
    localparam int END_W       = 63;
    localparam int ACC_W       = 26;
    localparam int TOTAL_W     = 28;
    localparam int THR_W       = 27;
    localparam int WLEN_W      = 5;
    localparam int OFF_W       = 24;
    localparam int OFF_SUM_W   = 27;
    localparam int NUM_OFFSETS = 5;
    localparam int CFG_W       = 27;
    localparam int CFG_IDX_W   = 3;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 5'd16;

    typedef logic [STAGE_W-1:0] stage_t;

    localparam stage_t STAGE_TRACKING   = 2'd0;
    localparam stage_t STAGE_PREDICTION = 2'd1;
    localparam stage_t STAGE_PLANNING   = 2'd2;
    localparam stage_t STAGE_CONTROL    = 2'd3;

    localparam logic [OP_W-1:0] OP_TRACKING   = 3'd0;
    localparam logic [OP_W-1:0] OP_PREDICTION = 3'd1;
    localparam logic [OP_W-1:0] OP_PLANNING   = 3'd2;
    localparam logic [OP_W-1:0] OP_CONTROL    = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD      = 3'd0,
        CFG_WINDOW_LENGTH  = 3'd1,
        CFG_SENSOR_OFS     = 3'd2,
        CFG_PERCEPTION_OFS = 3'd3,
        CFG_PLANNING_OFS   = 3'd4,
        CFG_CONTROL_OFS    = 3'd5,
        CFG_VEHICLE_OFS    = 3'd6
    } cfg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_EMPTY    = 2'd0,
        STATUS_WITHIN   = 2'd1,
        STATUS_EXCEEDED = 2'd2
    } status_t;

    typedef enum logic {
        ITEM_SAMPLE = 1'b0,
        ITEM_TICK   = 1'b1
    } item_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE   = 2'd0,
        BK_SEARCH = 2'd1,
        BK_SUM    = 2'd2,
        BK_REPORT = 2'd3
    } back_state_t;

    typedef struct packed {
        item_kind_t          kind;
        stage_t              stage;
        logic [TIME_W-1:0]   time_ns;
        logic [LAT_W-1:0]    lat_us;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic [THR_W-1:0]     threshold;
        logic [WLEN_W-1:0]    window_length;
        logic [OFF_SUM_W-1:0] off_sum;
    } cfg_t;

    typedef struct packed {
        logic                          valid;
        logic [TOTAL_W-1:0]            total;
        status_t                       status;
        logic [STAGES-1:0]             empty_mask;
        logic [STAGES-1:0][LAT_W-1:0]  latest;
    } result_t;

endpackage

// ===== rtl/core/clpm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
module clpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/clpm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts commands, sorts them into samples and ticks, and queues them.
module clpm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [clpm_pkg::OP_W-1:0]   operation,
    input  logic [clpm_pkg::TIME_W-1:0] event_time_ns,
    input  logic [clpm_pkg::LAT_W-1:0]  latency_us,
    input  logic                        pop,
    output clpm_pkg::q_head_t           head
);
    import clpm_pkg::*;

    item_t               q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                accept;
    logic                known;
    logic                push;
    item_t               item_in;

    // Sample operations carry their stage code directly; unknown codes are dropped.
    always_comb
    begin
        item_in.time_ns = event_time_ns;
        item_in.lat_us  = latency_us;
        item_in.kind    = ITEM_SAMPLE;
        item_in.stage   = operation[STAGE_W-1:0];
        known           = 1'b0;
        unique case (operation) inside
            OP_TRACKING, OP_PREDICTION, OP_PLANNING, OP_CONTROL:
            begin
                known = 1'b1;
            end
            OP_TICK:
            begin
                known        = 1'b1;
                item_in.kind = ITEM_TICK;
            end
            default:
            begin
                known = 1'b0;
            end
        endcase
    end

    assign busy   = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign accept = start && !busy;
    assign push   = accept && known;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_reg[rd_ptr_reg];

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond its depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("back end popped an empty queue");

    a_drop_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !known && !pop) |=> $stable(count_reg))
        else $error("unknown operation entered the queue");

endmodule

// ===== rtl/core/clpm_back.sv =====
`timescale 1ns / 1ps
// Back end: sample windows in RAM, the chained tick search and the result register.
module clpm_back #(
    parameter int WINDOW_MAX = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  clpm_pkg::q_head_t head,
    output logic              pop,
    input  clpm_pkg::cfg_t    cfg,
    output clpm_pkg::result_t result
);
    import clpm_pkg::*;

    localparam int SLOT_W  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
    localparam int DEPTH   = STAGES * WINDOW_MAX;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CMP_W   = ((FILL_W > WLEN_W) ? FILL_W : WLEN_W) + 1;
    localparam int ENTRY_W = TIME_W + LAT_W;

    back_state_t         state_reg, state_next;
    logic [SLOT_W-1:0]   write_slot_reg [STAGES];
    logic [SLOT_W-1:0]   write_slot_next [STAGES];
    logic [FILL_W-1:0]   fill_reg [STAGES];
    logic [FILL_W-1:0]   fill_next [STAGES];
    logic [LAT_W-1:0]    latest_reg [STAGES];
    logic [LAT_W-1:0]    latest_next [STAGES];

    stage_t              cur_stage_reg, cur_stage_next;
    logic [END_W-1:0]    limit_reg, limit_next;
    logic                iss_active_reg, iss_active_next;
    logic [FILL_W-1:0]   iss_left_reg, iss_left_next;
    logic [SLOT_W-1:0]   iss_slot_reg, iss_slot_next;

    logic                p1_v_reg, p1_v_next, p1_last_reg, p1_last_next;
    logic                p2_v_reg, p2_v_next, p2_last_reg, p2_last_next;
    logic                p3_v_reg, p3_v_next, p3_last_reg, p3_last_next;
    logic [TIME_W-1:0]   p2_time_reg;
    logic [PROD_W-1:0]   p2_prod_reg, p2_prod_next;
    logic [LAT_W-1:0]    p2_lat_reg;
    logic [END_W-1:0]    p3_end_reg, p3_end_next;
    logic [LAT_W-1:0]    p3_lat_reg;

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    result_t             result_reg, result_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    logic [TIME_W-1:0]   rd_time;
    logic [LAT_W-1:0]    rd_lat;

    stage_t              sel_stage;
    logic [FILL_W-1:0]   sel_fill;
    logic [SLOT_W-1:0]   sel_slot;
    logic [CMP_W-1:0]    eff_len, fill_inc;
    logic                hit;

    function automatic logic [ADDR_W-1:0] stage_base(input stage_t st);
        stage_base = ADDR_W'(st) * ADDR_W'(WINDOW_MAX);
    endfunction

    // Step one slot back toward older entries, wrapping at the window end.
    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s);
        slot_back = (s == '0) ? SLOT_W'(WINDOW_MAX - 1) : s - 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_fwd(input logic [SLOT_W-1:0] s);
        slot_fwd = (s == SLOT_W'(WINDOW_MAX - 1)) ? '0 : s + 1'b1;
    endfunction

    clpm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_time   = ram_rdata[ENTRY_W-1:LAT_W];
    assign rd_lat    = ram_rdata[LAT_W-1:0];
    assign ram_raddr = stage_base(cur_stage_reg) + ADDR_W'(iss_slot_reg);

    assign p2_prod_next = PROD_W'(rd_lat) * PROD_W'(NS_PER_US);
    assign p3_end_next  = END_W'(p2_time_reg) + END_W'(p2_prod_reg);

    // One stage index serves the idle sample write or tick start and the next search in the walk.
    always_comb
    begin
        if (state_reg == BK_IDLE)
        begin
            sel_stage = (head.item.kind == ITEM_SAMPLE) ? head.item.stage : STAGE_CONTROL;
        end
        else
        begin
            sel_stage = stage_t'(cur_stage_reg - 1'b1);
        end
    end

    assign sel_fill = fill_reg[sel_stage];
    assign sel_slot = write_slot_reg[sel_stage];

    always_comb
    begin
        if (cfg.window_length == '0)
        begin
            eff_len = CMP_W'(1);
        end
        else if (CMP_W'(cfg.window_length) > CMP_W'(WINDOW_MAX))
        begin
            eff_len = CMP_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = CMP_W'(cfg.window_length);
        end
    end

    assign fill_inc = CMP_W'(sel_fill) + 1'b1;

    assign hit = p3_v_reg && ((cur_stage_reg == STAGE_CONTROL) || (p3_end_reg < limit_reg));

    always_comb
    begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        fill_next       = fill_reg;
        latest_next     = latest_reg;
        cur_stage_next  = cur_stage_reg;
        limit_next      = limit_reg;
        iss_active_next = 1'b0;
        iss_left_next   = iss_left_reg;
        iss_slot_next   = iss_slot_reg;
        p1_v_next       = 1'b0;
        p1_last_next    = p1_last_reg;
        p2_v_next       = p1_v_reg;
        p2_last_next    = p1_last_reg;
        p3_v_next       = p2_v_reg;
        p3_last_next    = p2_last_reg;
        acc_next        = acc_reg;
        total_next      = total_reg;
        result_next       = result_reg;
        result_next.valid = 1'b0;
        pop       = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = stage_base(sel_stage) + ADDR_W'(sel_slot);
        ram_wdata = {head.item.time_ns, head.item.lat_us};

        unique case (state_reg)
            BK_IDLE:
            begin
                p2_v_next = 1'b0;
                p3_v_next = 1'b0;
                if (head.valid)
                begin
                    pop = 1'b1;
                    if (head.item.kind == ITEM_SAMPLE)
                    begin
                        ram_we                     = 1'b1;
                        write_slot_next[sel_stage] = slot_fwd(sel_slot);
                        fill_next[sel_stage]       = FILL_W'((fill_inc > eff_len) ? eff_len
                                                                                  : fill_inc);
                        latest_next[sel_stage]     = head.item.lat_us;
                    end
                    else
                    begin
                        acc_next = '0;
                        if (sel_fill != '0)
                        begin
                            // Control contributes its newest entry unconditionally.
                            state_next      = BK_SEARCH;
                            cur_stage_next  = STAGE_CONTROL;
                            iss_active_next = 1'b1;
                            iss_left_next   = FILL_W'(1);
                            iss_slot_next   = slot_back(sel_slot);
                        end
                        else
                        begin
                            state_next = BK_SUM;
                        end
                    end
                end
            end

            BK_SEARCH:
            begin
                if (iss_active_reg)
                begin
                    p1_v_next       = 1'b1;
                    p1_last_next    = (iss_left_reg == FILL_W'(1));
                    iss_left_next   = iss_left_reg - 1'b1;
                    iss_active_next = (iss_left_reg != FILL_W'(1));
                    iss_slot_next   = slot_back(iss_slot_reg);
                end
                if (hit)
                begin
                    acc_next        = acc_reg + ACC_W'(p3_lat_reg);
                    p1_v_next       = 1'b0;
                    p2_v_next       = 1'b0;
                    p3_v_next       = 1'b0;
                    iss_active_next = 1'b0;
                    // The chain goes on only above tracking, into a filled window, past nonzero latency or control.
                    if ((cur_stage_reg != STAGE_TRACKING) && (sel_fill != '0) &&
                        ((cur_stage_reg == STAGE_CONTROL) || (p3_lat_reg != '0)))
                    begin
                        cur_stage_next  = sel_stage;
                        limit_next      = p3_end_reg;
                        iss_active_next = 1'b1;
                        iss_left_next   = sel_fill;
                        iss_slot_next   = slot_back(sel_slot);
                    end
                    else
                    begin
                        state_next = BK_SUM;
                    end
                end
                else if (p3_v_reg && p3_last_reg)
                begin
                    p1_v_next       = 1'b0;
                    p2_v_next       = 1'b0;
                    p3_v_next       = 1'b0;
                    iss_active_next = 1'b0;
                    state_next      = BK_SUM;
                end
            end

            BK_SUM:
            begin
                p2_v_next  = 1'b0;
                p3_v_next  = 1'b0;
                total_next = TOTAL_W'(acc_reg) +
                             {{(TOTAL_W - OFF_SUM_W){cfg.off_sum[OFF_SUM_W-1]}}, cfg.off_sum};
                state_next = BK_REPORT;
            end

            BK_REPORT:
            begin
                p2_v_next         = 1'b0;
                p3_v_next         = 1'b0;
                result_next.valid = 1'b1;
                result_next.total = total_reg;
                for (int s = 0; s < STAGES; s++)
                begin
                    result_next.empty_mask[s] = (fill_reg[s] == '0);
                    result_next.latest[s]     = (fill_reg[s] == '0) ? '0 : latest_reg[s];
                end
                if (result_next.empty_mask != '0)
                begin
                    result_next.status = STATUS_EMPTY;
                end
                else if ($signed(total_reg) > $signed({1'b0, cfg.threshold}))
                begin
                    result_next.status = STATUS_EXCEEDED;
                end
                else
                begin
                    result_next.status = STATUS_WITHIN;
                end
                state_next = BK_IDLE;
            end

            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            cur_stage_reg  <= STAGE_CONTROL;
            iss_active_reg <= 1'b0;
            iss_left_reg   <= '0;
            p1_v_reg       <= 1'b0;
            p2_v_reg       <= 1'b0;
            p3_v_reg       <= 1'b0;
            result_reg     <= '0;
            for (int s = 0; s < STAGES; s++)
            begin
                write_slot_reg[s] <= '0;
                fill_reg[s]       <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cur_stage_reg  <= cur_stage_next;
            iss_active_reg <= iss_active_next;
            iss_left_reg   <= iss_left_next;
            p1_v_reg       <= p1_v_next;
            p2_v_reg       <= p2_v_next;
            p3_v_reg       <= p3_v_next;
            result_reg     <= result_next;
            write_slot_reg <= write_slot_next;
            fill_reg       <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        latest_reg   <= latest_next;
        limit_reg    <= limit_next;
        iss_slot_reg <= iss_slot_next;
        p1_last_reg  <= p1_last_next;
        p2_last_reg  <= p2_last_next;
        p3_last_reg  <= p3_last_next;
        p2_time_reg  <= rd_time;
        p2_prod_reg  <= p2_prod_next;
        p2_lat_reg   <= rd_lat;
        p3_end_reg   <= p3_end_next;
        p3_lat_reg   <= p2_lat_reg;
        acc_reg      <= acc_next;
        total_reg    <= total_next;
    end

    assign result = result_reg;

    a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.valid |=> !result_reg.valid)
        else $error("result strobe held for more than one cycle");

    a_status_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result_reg.valid |-> ((result_reg.status == STATUS_EMPTY) ==
                              (result_reg.empty_mask != '0)))
        else $error("status disagrees with the empty mask");

    a_issue_left: assert property (@(posedge clk) disable iff (!rst_n)
        iss_active_reg |-> (iss_left_reg != '0) && (state_reg == BK_SEARCH))
        else $error("window read issued with no entries left or outside the walk");

endmodule

// ===== rtl/core/chained_pipeline_latency_monitor_core.sv =====
`timescale 1ns / 1ps
// Top level of the chained pipeline latency monitor: configuration registers and the two halves.
//
//  Channel   | Handshake             | Payload
//  ----------+-----------------------+-------------------------------------------------
//  command   | start / busy          | operation, event_time_ns, latency_us
//  result    | result_valid (strobe) | total_latency_us, status, empty_mask, latest_*_us
//  config    | cfg_we                | cfg_index, cfg_data
//
// A command transaction completes on a rising edge with start high and busy low. A two-entry
// queue sits between the front end and the window engine, so busy only rises when both queue
// entries are taken. A sample is written to its window RAM at the same edge that pops it from
// the queue, and samples drain at one per cycle while the back end is idle. A tick walks the
// windows through the single RAM read port and a three-register end-time pipeline: it looks up
// the newest control entry, scans each further stage from its newest entry back until one ends
// before the previous end time, then sums and reports. Reset is asynchronous and active low; it
// empties all windows at once (no clearing pass, the RAM contents are only read within the fill
// counts). Each result transaction is on the ports for exactly one cycle and the receiver cannot
// stall it. The user must write configuration only while idle; the block does not enforce it.
module chained_pipeline_latency_monitor_core #(
    parameter int WINDOW_MAX = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [clpm_pkg::OP_W-1:0]           operation,
    input  logic [clpm_pkg::TIME_W-1:0]         event_time_ns,
    input  logic [clpm_pkg::LAT_W-1:0]          latency_us,
    input  logic                                cfg_we,
    input  logic [clpm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [clpm_pkg::CFG_W-1:0]          cfg_data,
    output logic                                result_valid,
    output logic signed [clpm_pkg::TOTAL_W-1:0] total_latency_us,
    output logic [clpm_pkg::STATUS_W-1:0]       status,
    output logic [clpm_pkg::STAGES-1:0]         empty_mask,
    output logic [clpm_pkg::LAT_W-1:0]          latest_tracking_us,
    output logic [clpm_pkg::LAT_W-1:0]          latest_prediction_us,
    output logic [clpm_pkg::LAT_W-1:0]          latest_planning_us,
    output logic [clpm_pkg::LAT_W-1:0]          latest_control_us
);
    import clpm_pkg::*;

    logic [THR_W-1:0]      threshold_reg, threshold_next;
    logic [WLEN_W-1:0]     window_length_reg, window_length_next;
    logic [OFF_W-1:0]      offset_reg [NUM_OFFSETS];
    logic [OFF_W-1:0]      offset_next [NUM_OFFSETS];
    logic [OFF_SUM_W-1:0]  off_sum_reg, off_sum_next;

    q_head_t               head;
    logic                  pop;
    cfg_t                  cfg;
    result_t               result;

    // Register decode; an index past the last register writes nothing.
    always_comb
    begin
        threshold_next     = threshold_reg;
        window_length_next = window_length_reg;
        offset_next        = offset_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:      threshold_next     = cfg_data[THR_W-1:0];
                CFG_WINDOW_LENGTH:  window_length_next = cfg_data[WLEN_W-1:0];
                CFG_SENSOR_OFS:     offset_next[0]     = cfg_data[OFF_W-1:0];
                CFG_PERCEPTION_OFS: offset_next[1]     = cfg_data[OFF_W-1:0];
                CFG_PLANNING_OFS:   offset_next[2]     = cfg_data[OFF_W-1:0];
                CFG_CONTROL_OFS:    offset_next[3]     = cfg_data[OFF_W-1:0];
                CFG_VEHICLE_OFS:    offset_next[4]     = cfg_data[OFF_W-1:0];
                default:            threshold_next     = threshold_reg;
            endcase
        end
    end

    // The five fixed offsets are to be changed by the user only while idle (the block does not
    // enforce it), so their sum is kept in a register and the tick adds one term instead of five.
    always_comb
    begin
        off_sum_next = '0;
        for (int i = 0; i < NUM_OFFSETS; i++)
        begin
            off_sum_next = off_sum_next +
                           {{(OFF_SUM_W - OFF_W){offset_reg[i][OFF_W-1]}}, offset_reg[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg     <= '0;
            window_length_reg <= WLEN_RESET;
            off_sum_reg       <= '0;
            for (int i = 0; i < NUM_OFFSETS; i++)
            begin
                offset_reg[i] <= '0;
            end
        end
        else
        begin
            threshold_reg     <= threshold_next;
            window_length_reg <= window_length_next;
            offset_reg        <= offset_next;
            off_sum_reg       <= off_sum_next;
        end
    end

    assign cfg.threshold     = threshold_reg;
    assign cfg.window_length = window_length_reg;
    assign cfg.off_sum       = off_sum_reg;

    clpm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .event_time_ns (event_time_ns),
        .latency_us    (latency_us),
        .pop           (pop),
        .head          (head)
    );

    clpm_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .cfg    (cfg),
        .result (result)
    );

    assign result_valid         = result.valid;
    assign total_latency_us     = result.total;
    assign status               = result.status;
    assign empty_mask           = result.empty_mask;
    assign latest_tracking_us   = result.latest[STAGE_TRACKING];
    assign latest_prediction_us = result.latest[STAGE_PREDICTION];
    assign latest_planning_us   = result.latest[STAGE_PLANNING];
    assign latest_control_us    = result.latest[STAGE_CONTROL];

endmodule
